@@ src/rnn_pkg.sv @@
// ----------------------------------------------------------------------------
// rnn_pkg: shared types and codes for the character RNN inference step
// Beat payloads, item kinds, weight groups, controller states and the
// command word from the controller to the datapath.
// ----------------------------------------------------------------------------
package rnn_pkg;

    localparam int FIELD_W = 6;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic [2:0] GROUP_INPUT      = 3'd0;
    localparam logic [2:0] GROUP_RECURRENT  = 3'd1;
    localparam logic [2:0] GROUP_OUTPUT     = 3'd2;
    localparam logic [2:0] GROUP_HIDDEN_B   = 3'd3;
    localparam logic [2:0] GROUP_OUTPUT_B   = 3'd4;

    typedef struct packed {
        logic               kind;
        logic [2:0]         weight_group;
        logic [5:0]         weight_row;
        logic [5:0]         weight_column;
        logic signed [15:0] weight_value;
        logic [5:0]         symbol;
        logic               first_of_sequence;
    } in_item_t;

    typedef struct packed {
        logic [5:0]         predicted_symbol;
        logic signed [31:0] best_logit;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIDDEN,
        ST_HDRAIN,
        ST_OUTPUT,
        ST_ODRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               issue;
        logic               out_phase;
        logic               first;
        logic               last;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic               emit;
    } cmd_t;

endpackage

@@ src/rnn_ctrl.sv @@
// ----------------------------------------------------------------------------
// rnn_ctrl: step sequencer
// Walks hidden rows then output rows, one MAC beat a cycle, waits for the
// datapath pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module rnn_ctrl #(
    parameter int HIDDEN_UNITS = 32,
    parameter int VOCAB_SIZE   = 64,
    parameter int DRAIN        = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          cfg_we,
    input  logic [6:0]    cfg_data,
    input  logic          out_free,
    output logic          idle,
    output rnn_pkg::cmd_t cmd
);

    localparam int DW = $clog2(DRAIN + 1);
    localparam logic [5:0] H_LAST = 6'(HIDDEN_UNITS - 1);

    rnn_pkg::state_t state_reg, state_next;
    logic [5:0]    row_reg, row_next;
    logic [5:0]    col_reg, col_next;
    logic [DW-1:0] drain_reg, drain_next;
    logic [6:0]    count_reg;
    logic [5:0]    out_last;

    // hold the symbol count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 7'd62;
        else if (cfg_we)
            count_reg <= cfg_data;
    end

    // clamp the count to one through the vocabulary size
    always_comb
    begin
        if (count_reg == 7'd0)
            out_last = 6'd0;
        else if (int'(count_reg) > VOCAB_SIZE)
            out_last = 6'(VOCAB_SIZE - 1);
        else
            out_last = 6'(count_reg - 7'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rnn_pkg::ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            drain_reg <= drain_next;
        end
    end

    // sequence the rows and columns
    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        drain_next    = drain_reg;
        cmd           = '0;
        cmd.row       = row_reg;
        cmd.col       = col_reg;
        cmd.first     = (col_reg == 6'd0);
        cmd.last      = (col_reg == H_LAST);
        idle          = (state_reg == rnn_pkg::ST_IDLE);
        unique case (state_reg)
            rnn_pkg::ST_IDLE:
            begin
                row_next = '0;
                col_next = '0;
                if (start)
                    state_next = rnn_pkg::ST_HIDDEN;
            end
            rnn_pkg::ST_HIDDEN, rnn_pkg::ST_OUTPUT:
            begin
                cmd.issue     = 1'b1;
                cmd.out_phase = (state_reg == rnn_pkg::ST_OUTPUT);
                col_next      = col_reg + 6'd1;
                drain_next    = '0;
                if (col_reg == H_LAST)
                begin
                    col_next = '0;
                    row_next = row_reg + 6'd1;
                    if (state_reg == rnn_pkg::ST_HIDDEN && row_reg == H_LAST)
                        state_next = rnn_pkg::ST_HDRAIN;
                    else if (state_reg == rnn_pkg::ST_OUTPUT && row_reg == out_last)
                        state_next = rnn_pkg::ST_ODRAIN;
                end
            end
            rnn_pkg::ST_HDRAIN, rnn_pkg::ST_ODRAIN:
            begin
                row_next   = '0;
                col_next   = '0;
                drain_next = drain_reg + DW'(1);
                if (drain_reg == DW'(DRAIN - 1))
                    state_next = (state_reg == rnn_pkg::ST_HDRAIN) ?
                                 rnn_pkg::ST_OUTPUT : rnn_pkg::ST_EMIT;
            end
            rnn_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = rnn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rnn_pkg::ST_IDLE;
            end
        endcase
    end

    a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (state_reg == rnn_pkg::ST_HIDDEN || state_reg == rnn_pkg::ST_OUTPUT))
        else $error("MAC beat issued outside a compute phase");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result emitted into a full output register");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg == rnn_pkg::ST_HIDDEN)
        else $error("step start did not enter the hidden phase");
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> idle)
        else $error("sequencer not idle after emit");

endmodule

@@ src/rnn_dp.sv @@
// ----------------------------------------------------------------------------
// rnn_dp: weight stores, MAC pipeline, tanh lookup and argmax
// One shared multiply-accumulate fed from the weight memories and the
// double-buffered hidden state; results land in the output register.
// ----------------------------------------------------------------------------
module rnn_dp #(
    parameter int HIDDEN_UNITS = 32,
    parameter int VOCAB_SIZE   = 64,
    parameter int TANH_ENTRIES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_we,
    input  logic                step_start,
    input  rnn_pkg::in_item_t   item,
    input  rnn_pkg::cmd_t       cmd,
    output logic                out_free,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rnn_pkg::out_item_t  rsp_data
);

    localparam int HW    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int VW    = $clog2(VOCAB_SIZE);
    localparam int TW    = $clog2(TANH_ENTRIES);
    localparam int IX_D  = HIDDEN_UNITS * VOCAB_SIZE;
    localparam int HH_D  = HIDDEN_UNITS * HIDDEN_UNITS;
    localparam int IX_AW = (IX_D > 1) ? $clog2(IX_D) : 1;
    localparam int HH_AW = (HH_D > 1) ? $clog2(HH_D) : 1;
    localparam int ACC_W = 33 + $clog2(HIDDEN_UNITS + 2);

    typedef logic signed [15:0] lut_t [TANH_ENTRIES];

    // shift-subtract division for building the table
    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], a[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sample tanh over minus four to four, saturating at the ends
    function automatic lut_t build_lut();
        lut_t        lut;
        logic [63:0] one;
        logic [63:0] d;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] t;
        logic signed [63:0] sum;
        one = 64'd1 << 30;
        for (int k = 0; k < TANH_ENTRIES; k++)
        begin
            d = (2 * k >= TANH_ENTRIES) ? 64'(2 * k - TANH_ENTRIES) :
                                          64'(TANH_ENTRIES - 2 * k);
            z    = udiv(d << 30, 64'(2 * TANH_ENTRIES));
            term = one;
            sum  = signed'(one);
            for (int i = 1; i <= 12; i++)
            begin
                term = udiv((term * z) >> 30, 64'(i));
                if (i % 2 == 1)
                    sum = sum - signed'(term);
                else
                    sum = sum + signed'(term);
            end
            if (sum < 0)
                sum = '0;
            if (sum > signed'(one))
                sum = signed'(one);
            e = unsigned'(sum);
            for (int i = 0; i < 4; i++)
                e = (e * e) >> 30;
            den = one + e;
            t   = udiv(((one - e) << 12) + (den >> 1), den);
            lut[k] = (2 * k < TANH_ENTRIES) ? 16'(-signed'(t)) : 16'(t);
        end
        return lut;
    endfunction

    localparam lut_t TANH_LUT = build_lut();

    logic signed [15:0] wxh_mem [IX_D];
    logic signed [15:0] whh_mem [HH_D];
    logic signed [15:0] why_mem [IX_D];
    logic signed [15:0] hb_mem  [HIDDEN_UNITS];
    logic signed [15:0] by_mem  [VOCAB_SIZE];
    logic signed [15:0] h_bank_reg [2][HIDDEN_UNITS];

    logic [5:0] sym_reg;
    logic       zero_reg;
    logic       cur_reg;

    logic       sym_ok;
    logic       row_ok;
    logic       col_h_ok;
    logic       col_v_ok;
    logic [IX_AW-1:0] ld_ix_addr;
    logic [HH_AW-1:0] ld_hh_addr;
    logic [IX_AW-1:0] ld_ow_addr;

    assign sym_ok   = int'(sym_reg) < VOCAB_SIZE;
    assign row_ok   = int'(item.weight_row) < HIDDEN_UNITS;
    assign col_h_ok = int'(item.weight_column) < HIDDEN_UNITS;
    assign col_v_ok = int'(item.weight_column) < VOCAB_SIZE;
    assign ld_ix_addr = IX_AW'(int'(item.weight_row) * VOCAB_SIZE + int'(item.weight_column));
    assign ld_hh_addr = HH_AW'(int'(item.weight_row) * HIDDEN_UNITS + int'(item.weight_column));
    assign ld_ow_addr = IX_AW'(int'(item.weight_row) * HIDDEN_UNITS + int'(item.weight_column));

    // write one weight word per load beat, drop out-of-range words
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            case (item.weight_group)
                rnn_pkg::GROUP_INPUT:
                    if (row_ok && col_v_ok)
                        wxh_mem[ld_ix_addr] <= item.weight_value;
                rnn_pkg::GROUP_RECURRENT:
                    if (row_ok && col_h_ok)
                        whh_mem[ld_hh_addr] <= item.weight_value;
                rnn_pkg::GROUP_OUTPUT:
                    if (int'(item.weight_row) < VOCAB_SIZE && col_h_ok)
                        why_mem[ld_ow_addr] <= item.weight_value;
                rnn_pkg::GROUP_HIDDEN_B:
                    if (row_ok)
                        hb_mem[item.weight_row[HW-1:0]] <= item.weight_value;
                rnn_pkg::GROUP_OUTPUT_B:
                    if (int'(item.weight_row) < VOCAB_SIZE)
                        by_mem[item.weight_row[VW-1:0]] <= item.weight_value;
                default:
                begin
                end
            endcase
        end
    end

    // read stage: memory data and hidden value for one MAC beat
    logic signed [15:0] r_wxh_reg, r_whh_reg, r_why_reg, r_hb_reg, r_by_reg, r_h_reg;
    logic       r_valid_reg, r_out_reg, r_first_reg, r_last_reg, r_symok_reg;
    logic [5:0] r_row_reg;
    logic       h_sel;

    assign h_sel = cmd.out_phase ? ~cur_reg : cur_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.issue && !cmd.out_phase)
        begin
            r_wxh_reg <= wxh_mem[IX_AW'(int'(cmd.row) * VOCAB_SIZE + int'(sym_reg))];
            r_whh_reg <= whh_mem[HH_AW'(int'(cmd.row) * HIDDEN_UNITS + int'(cmd.col))];
            r_hb_reg  <= hb_mem[cmd.row[HW-1:0]];
        end
        if (cmd.issue && cmd.out_phase)
        begin
            r_why_reg <= why_mem[IX_AW'(int'(cmd.row) * HIDDEN_UNITS + int'(cmd.col))];
            r_by_reg  <= by_mem[cmd.row[VW-1:0]];
        end
        r_h_reg     <= (zero_reg && !cmd.out_phase) ? 16'sd0 :
                       h_bank_reg[h_sel][cmd.col[HW-1:0]];
        r_out_reg   <= cmd.out_phase;
        r_first_reg <= cmd.first;
        r_last_reg  <= cmd.last;
        r_row_reg   <= cmd.row;
        r_symok_reg <= sym_ok;
    end

    // multiply stage
    logic signed [31:0]      m_prod_reg;
    logic signed [ACC_W-1:0] m_base_reg;
    logic       m_valid_reg, m_out_reg, m_first_reg, m_last_reg;
    logic [5:0] m_row_reg;
    logic signed [16:0] hid_base;

    assign hid_base = 17'(r_hb_reg) + (r_symok_reg ? 17'(r_wxh_reg) : 17'sd0);

    always_ff @(posedge clk)
    begin
        m_prod_reg  <= (r_out_reg ? r_why_reg : r_whh_reg) * r_h_reg;
        m_base_reg  <= r_out_reg ? (ACC_W'(r_by_reg) <<< 12) : (ACC_W'(hid_base) <<< 12);
        m_out_reg   <= r_out_reg;
        m_first_reg <= r_first_reg;
        m_last_reg  <= r_last_reg;
        m_row_reg   <= r_row_reg;
    end

    // accumulate stage
    logic signed [ACC_W-1:0] acc_reg, fin_reg, acc_sum;
    logic       f_valid_reg, f_out_reg;
    logic [5:0] f_row_reg;

    assign acc_sum = (m_first_reg ? m_base_reg : acc_reg) + ACC_W'(m_prod_reg);

    always_ff @(posedge clk)
    begin
        if (m_valid_reg)
            acc_reg <= acc_sum;
        if (m_valid_reg && m_last_reg)
            fin_reg <= acc_sum;
        f_out_reg <= m_out_reg;
        f_row_reg <= m_row_reg;
    end

    // finish stage: tanh index or saturated logit
    logic signed [ACC_W-13:0] act;
    logic signed [63:0] act_wide;
    logic [14:0]        act_off;
    logic [TW-1:0]      tidx;
    logic signed [31:0] logit;
    logic [TW-1:0]      g_tidx_reg;
    logic signed [31:0] g_logit_reg;
    logic       g_valid_reg, g_out_reg;
    logic [5:0] g_row_reg;

    assign act      = (ACC_W-12)'(fin_reg >>> 12);
    assign act_wide = 64'(act);
    assign act_off  = 15'(act_wide + 64'sd16384);

    always_comb
    begin
        if (act_wide < -64'sd16384)
            tidx = '0;
        else if (act_wide >= 64'sd16384)
            tidx = TW'(TANH_ENTRIES - 1);
        else
            tidx = TW'((int'(act_off) * TANH_ENTRIES) >> 15);
        if (act_wide > 64'sd2147483647)
            logit = 32'sh7FFFFFFF;
        else if (act_wide < -64'sd2147483648)
            logit = 32'sh80000000;
        else
            logit = 32'(act_wide);
    end

    always_ff @(posedge clk)
    begin
        g_tidx_reg  <= tidx;
        g_logit_reg <= logit;
        g_out_reg   <= f_out_reg;
        g_row_reg   <= f_row_reg;
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else
        begin
            r_valid_reg <= cmd.issue;
            m_valid_reg <= r_valid_reg;
            f_valid_reg <= m_valid_reg && m_last_reg;
            g_valid_reg <= f_valid_reg;
        end
    end

    // write back hidden state, track the best logit
    logic signed [31:0] best_reg;
    logic [5:0]         best_idx_reg;

    always_ff @(posedge clk)
    begin
        if (g_valid_reg && g_out_reg &&
            (g_row_reg == 6'd0 || g_logit_reg > best_reg))
        begin
            best_reg     <= g_logit_reg;
            best_idx_reg <= g_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < 2; b++)
                for (int i = 0; i < HIDDEN_UNITS; i++)
                    h_bank_reg[b][i] <= '0;
            cur_reg  <= 1'b0;
            zero_reg <= 1'b0;
            sym_reg  <= '0;
        end
        else
        begin
            if (g_valid_reg && !g_out_reg)
                h_bank_reg[~cur_reg][g_row_reg[HW-1:0]] <= TANH_LUT[g_tidx_reg];
            if (step_start)
            begin
                sym_reg  <= item.symbol;
                zero_reg <= item.first_of_sequence;
            end
            else if (cmd.emit)
            begin
                cur_reg  <= ~cur_reg;
                zero_reg <= 1'b0;
            end
        end
    end

    // output register
    logic      out_valid_reg;
    rnn_pkg::out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.predicted_symbol <= best_idx_reg;
            out_data_reg.best_logit       <= best_reg;
        end
    end

    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

@@ src/rnn_char_inference_step.sv @@
// ----------------------------------------------------------------------------
// rnn_char_inference_step: Elman RNN tanh cell, one character per step
// Loads Q4.12 weights and biases, runs the hidden and output layers on one
// shared MAC and returns the argmax symbol with its logit.
//
//  channel  | signals                       | beat
//  ---------+-------------------------------+------------------------------
//  request  | req_valid req_ready req_data  | one load word or one step
//  response | rsp_valid rsp_ready rsp_data  | predicted symbol, best logit
//  config   | cfg_we cfg_data               | symbol count, no wait
//
// A step runs every hidden row and then the output rows up to the symbol
// count through the single shared multiply-accumulate unit.
// Reset clears the hidden state and the controller; no clearing pass.
// A new request is taken while a result waits; a step stalls only at its
// end when the previous result is still not taken.
// ----------------------------------------------------------------------------
module rnn_char_inference_step #(
    parameter int HIDDEN_UNITS = 32,
    parameter int VOCAB_SIZE   = 64,
    parameter int TANH_ENTRIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  rnn_pkg::in_item_t  req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rnn_pkg::out_item_t rsp_data,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_data
);

    logic          idle;
    logic          out_free;
    logic          accept;
    rnn_pkg::cmd_t cmd;

    assign req_ready = idle;
    assign accept    = req_valid && idle;

    rnn_ctrl #(
        .HIDDEN_UNITS(HIDDEN_UNITS),
        .VOCAB_SIZE  (VOCAB_SIZE),
        .DRAIN       (8)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && req_data.kind == rnn_pkg::KIND_STEP),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .out_free(out_free),
        .idle    (idle),
        .cmd     (cmd)
    );

    rnn_dp #(
        .HIDDEN_UNITS(HIDDEN_UNITS),
        .VOCAB_SIZE  (VOCAB_SIZE),
        .TANH_ENTRIES(TANH_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_we   (accept && req_data.kind == rnn_pkg::KIND_LOAD),
        .step_start(accept && req_data.kind == rnn_pkg::KIND_STEP),
        .item      (req_data),
        .cmd       (cmd),
        .out_free  (out_free),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule
